// ===== sv/sacl_pkg.sv =====
// Package for the alarm change logger: sizes, codes, types and the reset masks.
package sacl_pkg;

	localparam int HIST_DEPTH = 8;
	localparam int NUM_GROUPS = 12;

	// Fixed visible read window and group code space
	localparam int READ_SLOTS = 8;
	localparam int GROUP_CODES = 16;

	typedef logic [1:0]        op_t;
	typedef logic [3:0]        group_t;
	typedef logic [31:0]       word_t;
	typedef logic signed [8:0] amount_t;
	typedef logic [2:0]        ridx_t;
	typedef logic [7:0]        count_t;
	typedef logic [1:0]        cfg_idx_t;

	// Operation codes
	localparam op_t OP_SAMPLE   = 2'd0;
	localparam op_t OP_WATCHDOG = 2'd1;
	localparam op_t OP_AMEND    = 2'd2;
	localparam op_t OP_READ     = 2'd3;

	// Register indexes
	localparam cfg_idx_t REG_MASK_0_5  = 2'd0;
	localparam cfg_idx_t REG_MASK_6    = 2'd1;
	localparam cfg_idx_t REG_MASK_7    = 2'd2;
	localparam cfg_idx_t REG_THRESHOLD = 2'd3;

	localparam word_t  MASK_0_5_RST  = 32'h0000_2490;
	localparam word_t  MASK_6_RST    = 32'h0012_4800;
	localparam word_t  MASK_7_RST    = 32'h0E0E_0092;
	localparam count_t THRESHOLD_RST = 8'd3;

	localparam group_t WATCHDOG_GROUP = 4'd7;
	localparam word_t  WATCHDOG_WORD  = 32'hFFFF_FFFF;
	localparam count_t COUNT_MAX      = 8'd255;

	// One history entry
	typedef struct packed {
		group_t group;
		word_t  alarm;
	} hist_entry_t;

	// Control into each history cell
	typedef struct packed {
		logic        shift;
		hist_entry_t prev;
	} hist_ctl_t;

endpackage

// ===== sv/sacl_hist_cell.sv =====
// One stage of the newest-first history shift register.
module sacl_hist_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sacl_pkg::hist_ctl_t ctl,
	output sacl_pkg::hist_entry_t nxt,
	output sacl_pkg::hist_entry_t cur
);
	import sacl_pkg::*;

	hist_entry_t entry_q;

	// Take the neighbour's entry on a push, else hold
	always_comb begin
		nxt = ctl.shift ? ctl.prev : entry_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			entry_q <= nxt;
		end
	end

	assign cur = entry_q;

endmodule

// ===== sv/sacl_group_cell.sv =====
// Last recorded alarm word of one group, with its own equality compare.
module sacl_group_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  sacl_pkg::word_t word,
	output logic            same
);
	import sacl_pkg::*;

	word_t last_q;

	// Compare the incoming word against the held one
	assign same = (last_q == word);

	// Record on a logged sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (wr) begin
			last_q <= word;
		end
	end

endmodule

// ===== sv/safety_alarm_change_logger.sv =====
// An accepted transaction's result is registered in the single output register. One
// transaction per cycle is taken except while that register is full and out_stall is
// high; the history row shifts and the group cells compare in the same cycle. Reset:
// asynchronous, active low; clears history, last words, count, fault flag and restores
// the ignore masks and threshold to their defaults. No clearing pass is needed.
module safety_alarm_change_logger (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  sacl_pkg::op_t        op,
	input  sacl_pkg::group_t     group,
	input  sacl_pkg::word_t      alarm_word,
	input  sacl_pkg::amount_t    amount,
	input  logic                 normal_voltage,
	input  logic                 ign_off_window,
	input  sacl_pkg::ridx_t      read_index,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 logged,
	output sacl_pkg::count_t     error_count,
	output logic                 hw_fault,
	output sacl_pkg::group_t     entry_group,
	output sacl_pkg::word_t      entry_alarm,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  sacl_pkg::cfg_idx_t   cfg_index,
	input  sacl_pkg::word_t      cfg_data
);
	import sacl_pkg::*;

	word_t  mask_0_5_q;
	word_t  mask_6_q;
	word_t  mask_7_q;
	count_t thr_q;
	count_t cnt_q;
	logic   fault_q;

	logic        out_valid_q;
	logic        logged_q;
	count_t      count_q;
	logic        hw_fault_q;
	hist_entry_t entry_q;

	logic        acc;
	logic        sample_en;
	logic        group_ok;
	word_t       mask;
	logic        do_log;
	logic        do_wd;
	logic        push;
	hist_entry_t push_entry;
	count_t      cnt_nxt;
	logic        fault_nxt;
	logic signed [9:0] amend_sum;
	logic [GROUP_CODES-1:0] same_all;
	logic [NUM_GROUPS-1:0]  same_vec;

	hist_ctl_t   hctl [HIST_DEPTH];
	hist_entry_t hnxt [HIST_DEPTH];
	hist_entry_t hcur [HIST_DEPTH];
	hist_entry_t read_slot [READ_SLOTS];

	// Accept while the output register is free or being drained
	assign in_stall  = out_valid_q && out_stall;
	assign acc       = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_0_5_q <= MASK_0_5_RST;
			mask_6_q   <= MASK_6_RST;
			mask_7_q   <= MASK_7_RST;
			thr_q      <= THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MASK_0_5:  mask_0_5_q <= cfg_data;
				REG_MASK_6:    mask_6_q   <= cfg_data;
				REG_MASK_7:    mask_7_q   <= cfg_data;
				REG_THRESHOLD: thr_q      <= cfg_data[7:0];
				default:       thr_q      <= thr_q;
			endcase
		end
	end

	// Select the ignore mask of the sampled group
	always_comb begin
		if (group <= 4'd5) begin
			mask = mask_0_5_q;
		end else if (group == 4'd6) begin
			mask = mask_6_q;
		end else if (group == 4'd7) begin
			mask = mask_7_q;
		end else begin
			mask = '0;
		end
	end

	// Row of group cells
	for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
		sacl_group_cell u_grp (
			.clk    (clk),
			.arst_n (arst_n),
			.wr     (do_log && (group == 4'(g))),
			.word   (alarm_word),
			.same   (same_vec[g])
		);
	end

	always_comb begin
		same_all = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			same_all[g] = same_vec[g];
		end
	end

	// Decide whether this transaction pushes a history entry
	assign sample_en = acc && (op == OP_SAMPLE) && normal_voltage && ign_off_window;
	assign group_ok  = (32'(group) < NUM_GROUPS);
	assign do_log    = sample_en && group_ok && ((alarm_word & ~mask) != '0)
		&& !same_all[group];
	assign do_wd     = acc && (op == OP_WATCHDOG) && normal_voltage;
	assign push      = do_log || do_wd;

	always_comb begin
		push_entry.group = do_wd ? WATCHDOG_GROUP : group;
		push_entry.alarm = do_wd ? WATCHDOG_WORD : alarm_word;
	end

	// Advance the error count: saturating increment or clamped amend
	assign amend_sum = $signed({2'b00, cnt_q}) + 10'(amount);

	always_comb begin
		cnt_nxt = cnt_q;
		if (push) begin
			cnt_nxt = (cnt_q == COUNT_MAX) ? COUNT_MAX : cnt_q + 8'd1;
		end else if (acc && (op == OP_AMEND)) begin
			if (amend_sum < 0) begin
				cnt_nxt = '0;
			end else if (amend_sum > $signed(10'(COUNT_MAX))) begin
				cnt_nxt = COUNT_MAX;
			end else begin
				cnt_nxt = amend_sum[7:0];
			end
		end
	end

	assign fault_nxt = sample_en ? (cnt_nxt > thr_q) : fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			fault_q <= 1'b0;
		end else begin
			cnt_q   <= cnt_nxt;
			fault_q <= fault_nxt;
		end
	end

	// Chain of history cells, each fed by its neighbour
	for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_hist
		if (k == 0) begin : g_head
			assign hctl[k] = '{shift: push, prev: push_entry};
		end else begin : g_body
			assign hctl[k] = '{shift: push, prev: hcur[k-1]};
		end
		sacl_hist_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (hctl[k]),
			.nxt    (hnxt[k]),
			.cur    (hcur[k])
		);
	end

	// Read window over the updated history; slots past the depth read as zero
	always_comb begin
		for (int k = 0; k < READ_SLOTS; k++) begin
			read_slot[k] = '0;
			if (k < HIST_DEPTH) begin
				read_slot[k] = hnxt[k];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			logged_q   <= push;
			count_q    <= cnt_nxt;
			hw_fault_q <= fault_nxt;
			entry_q    <= read_slot[read_index];
		end
	end

	assign out_valid   = out_valid_q;
	assign logged      = logged_q;
	assign error_count = count_q;
	assign hw_fault    = hw_fault_q;
	assign entry_group = entry_q.group;
	assign entry_alarm = entry_q.alarm;

	// Checks
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> out_valid_q)
		else $error("accepted transaction produced no result");

	a_count_falls_on_amend_only: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (op != OP_AMEND)) |=> (cnt_q >= $past(cnt_q)))
		else $error("error count dropped without an amend");

	a_fault_on_sample_only: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_en |=> (fault_q == $past(fault_q)))
		else $error("fault flag changed outside a status sample");

	a_push_lands_at_head: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (hcur[0] == $past(push_entry)))
		else $error("pushed entry not at history head");

endmodule
